>>> rtl/core/tpl_pkg.sv
// Package for the triangle point locator: default sizes, register indexes,
// function codes and the controller state type. No dependencies.
package tpl_pkg;

	localparam int DEF_MAX_TRIANGLES    = 1024;
	localparam int DEF_COORD_BITS       = 16;
	localparam int DEF_WEIGHT_FRAC_BITS = 16;

	localparam int TRI_INDEX_W = 10;
	localparam int COUNT_W     = 11;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 11;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TRIANGLE_COUNT = 1'b0,
		REG_WEIGHTS_ENABLE = 1'b1
	} reg_index_t;

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CACHE,
		ST_SCAN,
		ST_MUL,
		ST_TEST,
		ST_DIV,
		ST_FIN,
		ST_MISS
	} state_t;

endpackage

>>> rtl/core/tpl_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// Standalone; used by the triangle point locator for its triangle store.
module tpl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/triangle_point_locator_top.sv
// Triangle point locator top level: controller, shared multiplier and two dividers.
// Depends on tpl_pkg and tpl_ram.
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------
//  command   | start / busy         | func, tri_index, corner_*, point_x/y
//  result    | done (one cycle)     | found, triangle_number, weight_a/b/c
//  config    | cfg_we               | cfg_index, cfg_data
//
// A load writes one triangle and gives no result. A query first tests the
// cached triangle, if valid, and on a miss scans the store, testing each
// triangle whose bounding box holds the point, then runs the serial division
// of the weights when weights are on.
// The scan rate is set by the single read port of the triangle store.
// Reset clears the cache, configuration and control registers; the store is undefined until loaded.
// The receiver cannot stall: done is high for exactly one cycle per query.
module triangle_point_locator_top #(
	parameter int MAX_TRIANGLES    = tpl_pkg::DEF_MAX_TRIANGLES,
	parameter int COORD_BITS       = tpl_pkg::DEF_COORD_BITS,
	parameter int WEIGHT_FRAC_BITS = tpl_pkg::DEF_WEIGHT_FRAC_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   func,
	input  logic        [tpl_pkg::TRI_INDEX_W-1:0] tri_index,
	input  logic signed [COORD_BITS-1:0]           corner_a_x,
	input  logic signed [COORD_BITS-1:0]           corner_a_y,
	input  logic signed [COORD_BITS-1:0]           corner_b_x,
	input  logic signed [COORD_BITS-1:0]           corner_b_y,
	input  logic signed [COORD_BITS-1:0]           corner_c_x,
	input  logic signed [COORD_BITS-1:0]           corner_c_y,
	input  logic signed [COORD_BITS-1:0]           point_x,
	input  logic signed [COORD_BITS-1:0]           point_y,
	output logic                                   done,
	output logic                                   found,
	output logic        [tpl_pkg::TRI_INDEX_W-1:0] triangle_number,
	output logic        [WEIGHT_FRAC_BITS:0]       weight_a,
	output logic        [WEIGHT_FRAC_BITS:0]       weight_b,
	output logic        [WEIGHT_FRAC_BITS:0]       weight_c,
	input  logic                                   cfg_we,
	input  logic        [tpl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic        [tpl_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int C     = COORD_BITS;
	localparam int F     = WEIGHT_FRAC_BITS;
	localparam int WW    = F + 1;
	localparam int IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
	localparam int TN_W  = tpl_pkg::TRI_INDEX_W;
	localparam int DF    = C + 1;
	localparam int PW    = 2 * DF;
	localparam int ACC_W = PW + 1;
	localparam int MEM_W = 10 * C;
	localparam int DC_W  = (F > 1) ? $clog2(F + 1) : 1;

	tpl_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [tpl_pkg::COUNT_W-1:0] triangle_count_q;
	logic                        weights_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			triangle_count_q <= '0;
			weights_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (tpl_pkg::reg_index_t'(cfg_index))
				tpl_pkg::REG_TRIANGLE_COUNT: triangle_count_q <= cfg_data;
				tpl_pkg::REG_WEIGHTS_ENABLE: weights_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Triangle store: corners and bounding box in one word.
	logic [MEM_W-1:0] wdata, rdata;
	logic [IDX_W-1:0] raddr, waddr;
	logic             we;
	logic [31:0]      idx32;
	logic signed [C-1:0] min_x, max_x, min_y, max_y, ab_x, ab_y;

	assign idx32 = 32'(tri_index);
	assign waddr = idx32[IDX_W-1:0];

	always_comb begin
		ab_x  = (corner_a_x < corner_b_x) ? corner_a_x : corner_b_x;
		min_x = (ab_x < corner_c_x) ? ab_x : corner_c_x;
		ab_x  = (corner_a_x > corner_b_x) ? corner_a_x : corner_b_x;
		max_x = (ab_x > corner_c_x) ? ab_x : corner_c_x;
		ab_y  = (corner_a_y < corner_b_y) ? corner_a_y : corner_b_y;
		min_y = (ab_y < corner_c_y) ? ab_y : corner_c_y;
		ab_y  = (corner_a_y > corner_b_y) ? corner_a_y : corner_b_y;
		max_y = (ab_y > corner_c_y) ? ab_y : corner_c_y;
	end

	assign wdata = {corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x, corner_c_y,
		min_x, max_x, min_y, max_y};

	tpl_ram #(
		.WIDTH(MEM_W),
		.DEPTH(MAX_TRIANGLES)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	logic signed [C-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy, r_minx, r_maxx, r_miny, r_maxy;
	assign {r_ax, r_ay, r_bx, r_by, r_cx, r_cy, r_minx, r_maxx, r_miny, r_maxy} = rdata;

	// Query context.
	logic signed [C-1:0] px_q, py_q;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [IDX_W-1:0]    k_q, k_d;
	logic [IDX_W:0]      k_next;
	logic [IDX_W-1:0]    cached_q;
	logic                cache_valid_q;
	logic                in_box, more;

	assign count_d = (32'(triangle_count_q) > 32'(MAX_TRIANGLES)) ?
		CNT_W'(MAX_TRIANGLES) : CNT_W'(triangle_count_q);
	assign k_next  = {1'b0, k_q} + 1'b1;
	assign more    = 32'(k_next) < 32'(count_q);
	assign in_box  = (px_q >= r_minx) && (px_q <= r_maxx) &&
		(py_q >= r_miny) && (py_q <= r_maxy);

	// Edge vectors, products and accumulators.
	logic signed [DF-1:0]    a11_q, a12_q, a21_q, a22_q, dx_q, dy_q;
	logic signed [DF-1:0]    op_a, op_b;
	logic signed [PW-1:0]    prod_q;
	logic signed [ACC_W-1:0] det_q, n1_q, n2_q, acc_add;
	logic [2:0]              mstep_q;

	always_comb begin
		op_a = a11_q;
		op_b = a22_q;
		case (mstep_q)
			3'd1: begin op_a = a21_q; op_b = a12_q; end
			3'd2: begin op_a = a22_q; op_b = dx_q; end
			3'd3: begin op_a = a21_q; op_b = dy_q; end
			3'd4: begin op_a = a11_q; op_b = dy_q; end
			3'd5: begin op_a = a12_q; op_b = dx_q; end
			default: ;
		endcase
	end

	// Even products add, odd products subtract; each product is accumulated in the step after its multiply.
	assign acc_add = mstep_q[0] ? ACC_W'(prod_q) : -ACC_W'(prod_q);

	// Sign-normalized test values.
	logic signed [ACC_W-1:0] d_n, u_n, v_n;
	logic signed [ACC_W:0]   uv_sum;
	logic                    holds;

	always_comb begin
		if (det_q < 0) begin
			d_n = -det_q;
			u_n = -n1_q;
			v_n = -n2_q;
		end else begin
			d_n = det_q;
			u_n = n1_q;
			v_n = n2_q;
		end
		uv_sum = (ACC_W+1)'(u_n) + (ACC_W+1)'(v_n);
		holds  = (det_q != 0) && (u_n >= 0) && (v_n >= 0) && (uv_sum <= (ACC_W+1)'(d_n));
	end

	// Restoring dividers for both weights, one quotient bit per cycle each.
	logic [ACC_W-1:0] div_d_q, rb_q, rc_q;
	logic [ACC_W:0]   rb_sh, rc_sh;
	logic             b_ge, c_ge;
	logic [WW-1:0]    qb_q, qc_q;
	logic [DC_W-1:0]  div_cnt_q;

	assign rb_sh = {rb_q, 1'b0};
	assign rc_sh = {rc_q, 1'b0};
	assign b_ge  = rb_sh >= {1'b0, div_d_q};
	assign c_ge  = rc_sh >= {1'b0, div_d_q};

	logic from_cache_q;

	// Next state and store access.
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		raddr   = k_next[IDX_W-1:0];
		we      = 1'b0;
		unique case (state_q)
			tpl_pkg::ST_IDLE: begin
				if (start) begin
					if (tpl_pkg::func_t'(func) == tpl_pkg::FUNC_LOAD) begin
						we = idx32 < 32'(MAX_TRIANGLES);
					end else if (cache_valid_q && (32'(cached_q) < 32'(count_d))) begin
						raddr   = cached_q;
						k_d     = cached_q;
						state_d = tpl_pkg::ST_CACHE;
					end else if (count_d == '0) begin
						state_d = tpl_pkg::ST_MISS;
					end else begin
						raddr   = '0;
						k_d     = '0;
						state_d = tpl_pkg::ST_SCAN;
					end
				end
			end
			tpl_pkg::ST_CACHE: state_d = tpl_pkg::ST_MUL;
			tpl_pkg::ST_SCAN: begin
				if (in_box) begin
					state_d = tpl_pkg::ST_MUL;
				end else if (more) begin
					k_d = k_next[IDX_W-1:0];
				end else begin
					state_d = tpl_pkg::ST_MISS;
				end
			end
			tpl_pkg::ST_MUL: begin
				if (mstep_q == 3'd6) begin
					state_d = tpl_pkg::ST_TEST;
				end
			end
			tpl_pkg::ST_TEST: begin
				if (holds) begin
					state_d = weights_enable_q ? tpl_pkg::ST_DIV : tpl_pkg::ST_FIN;
				end else if (from_cache_q) begin
					// The cached triangle missed: fall back to a full scan.
					raddr = '0;
					k_d   = '0;
					state_d = (count_q == '0) ? tpl_pkg::ST_MISS : tpl_pkg::ST_SCAN;
				end else if (more) begin
					k_d     = k_next[IDX_W-1:0];
					state_d = tpl_pkg::ST_SCAN;
				end else begin
					state_d = tpl_pkg::ST_MISS;
				end
			end
			tpl_pkg::ST_DIV: begin
				if (div_cnt_q == DC_W'(F)) begin
					state_d = tpl_pkg::ST_FIN;
				end
			end
			tpl_pkg::ST_FIN:  state_d = tpl_pkg::ST_IDLE;
			tpl_pkg::ST_MISS: state_d = tpl_pkg::ST_IDLE;
			default:          state_d = tpl_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q != tpl_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= tpl_pkg::ST_IDLE;
			k_q           <= '0;
			cached_q      <= '0;
			cache_valid_q <= 1'b0;
			from_cache_q  <= 1'b0;
			mstep_q       <= '0;
			div_cnt_q     <= '0;
			done          <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			done    <= (state_q == tpl_pkg::ST_FIN) || (state_q == tpl_pkg::ST_MISS);
			if (state_q == tpl_pkg::ST_IDLE && start) begin
				if (tpl_pkg::func_t'(func) == tpl_pkg::FUNC_LOAD) begin
					cache_valid_q <= 1'b0;
				end
				from_cache_q <= (state_d == tpl_pkg::ST_CACHE);
			end
			if (state_q == tpl_pkg::ST_TEST && !holds) begin
				from_cache_q <= 1'b0;
			end
			if (state_d == tpl_pkg::ST_MUL && state_q != tpl_pkg::ST_MUL) begin
				mstep_q <= '0;
			end else if (state_q == tpl_pkg::ST_MUL) begin
				mstep_q <= mstep_q + 3'd1;
			end
			if (state_q == tpl_pkg::ST_TEST) begin
				div_cnt_q <= '0;
			end else if (state_q == tpl_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (state_q == tpl_pkg::ST_FIN) begin
				cache_valid_q <= 1'b1;
				cached_q      <= k_q;
			end else if (state_q == tpl_pkg::ST_MISS) begin
				cache_valid_q <= 1'b0;
				cached_q      <= '0;
			end
		end
	end

	// Datapath registers.
	logic [IDX_W+TN_W-1:0] k_ext;
	logic [WW-1:0]         w_one;

	assign k_ext = {{TN_W{1'b0}}, k_q};
	assign w_one = WW'(1) << F;

	always_ff @(posedge clk) begin
		if (state_q == tpl_pkg::ST_IDLE && start) begin
			px_q    <= point_x;
			py_q    <= point_y;
			count_q <= count_d;
		end
		if (state_q == tpl_pkg::ST_CACHE || state_q == tpl_pkg::ST_SCAN) begin
			a11_q <= DF'(r_bx) - DF'(r_ax);
			a12_q <= DF'(r_by) - DF'(r_ay);
			a21_q <= DF'(r_cx) - DF'(r_ax);
			a22_q <= DF'(r_cy) - DF'(r_ay);
			dx_q  <= DF'(px_q) - DF'(r_ax);
			dy_q  <= DF'(py_q) - DF'(r_ay);
			det_q <= '0;
			n1_q  <= '0;
			n2_q  <= '0;
		end
		if (state_q == tpl_pkg::ST_MUL) begin
			prod_q <= op_a * op_b;
			case (mstep_q)
				3'd1, 3'd2: det_q <= det_q + acc_add;
				3'd3, 3'd4: n1_q  <= n1_q + acc_add;
				3'd5, 3'd6: n2_q  <= n2_q + acc_add;
				default: ;
			endcase
		end
		if (state_q == tpl_pkg::ST_TEST) begin
			div_d_q <= d_n;
			qb_q    <= WW'(u_n == d_n);
			qc_q    <= WW'(v_n == d_n);
			rb_q    <= (u_n == d_n) ? '0 : u_n;
			rc_q    <= (v_n == d_n) ? '0 : v_n;
		end
		if (state_q == tpl_pkg::ST_DIV && div_cnt_q != DC_W'(F)) begin
			rb_q <= b_ge ? ACC_W'(rb_sh - {1'b0, div_d_q}) : rb_sh[ACC_W-1:0];
			rc_q <= c_ge ? ACC_W'(rc_sh - {1'b0, div_d_q}) : rc_sh[ACC_W-1:0];
			qb_q <= {qb_q[WW-2:0], b_ge};
			qc_q <= {qc_q[WW-2:0], c_ge};
		end
		if (state_q == tpl_pkg::ST_FIN) begin
			found           <= 1'b1;
			triangle_number <= k_ext[TN_W-1:0];
			if (weights_enable_q) begin
				weight_a <= w_one - qb_q - qc_q;
				weight_b <= qb_q;
				weight_c <= qc_q;
			end else begin
				weight_a <= '0;
				weight_b <= '0;
				weight_c <= '0;
			end
		end else if (state_q == tpl_pkg::ST_MISS) begin
			found           <= 1'b0;
			triangle_number <= '0;
			weight_a        <= '0;
			weight_b        <= '0;
			weight_c        <= '0;
		end
	end

endmodule
